/* rtl/core/spmf_pkg.sv */
// Shared constants, codes and request types for the strict-priority multilevel FIFO.
`default_nettype none

package spmf_pkg;

  // Queue geometry
  localparam int unsigned LEVELS    = 8;
  localparam int unsigned DEPTH     = 16;

  localparam int unsigned LVL_W     = $clog2(LEVELS);
  localparam int unsigned PTR_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W     = CNT_W + 1;
  localparam int unsigned ADDR_W    = LVL_W + PTR_W;
  localparam int unsigned MEM_DEPTH = LEVELS * (1 << PTR_W);

  // Field widths
  localparam int unsigned ID_W      = 37;
  localparam int unsigned TAG_W     = 8;
  localparam int unsigned ENTRY_W   = ID_W + TAG_W;
  localparam int unsigned LEVEL_W   = 3;
  localparam int unsigned STATUS_W  = 3;

  localparam logic [LEVEL_W-1:0] TOP_RESET = 3'd7;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 3'd0,
    ST_REMOVED  = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_BADLEVEL = 3'd4
  } status_e;

  // Entry store access for one request
  typedef struct packed {
    logic               wr_en;
    logic               rd_en;
    logic [ADDR_W-1:0]  addr;
    logic [ENTRY_W-1:0] wdata;
  } mem_req_t;

  // Result fields decided by the level control
  typedef struct packed {
    status_e            status;
    logic [LEVEL_W-1:0] level;
  } res_t;

endpackage

`default_nettype wire

/* rtl/core/strict_priority_multilevel_fifo.sv */
// Top level of the strict-priority multilevel FIFO queue.
`default_nettype none

// Strict-priority multilevel FIFO. Eight priority levels, each a circular FIFO
// of sixteen records (37-bit id plus 8-bit tag) kept in one shared entry
// memory. Each request is an insert, a remove or a clear and yields exactly
// one response. Inserts above the top level (cfg register, reset 7) answer
// "bad level"; inserts into a full level answer "level full"; both drop the
// record. A remove returns the oldest record of the highest non-empty level
// at or below the top level, or "queue empty". Clear resets every level,
// including levels above a lowered top level. Throughput is one request per
// clock while responses are taken, and the response is registered: the level
// encoder over the fill counts and the head/tail pointer update sit in the
// same cycle, and the entry memory is read once per remove that finds a
// record, at the same edge that accepts it. A response held by out_ready_i low
// blocks new requests, but one is accepted in the cycle the response is taken.
// top_level may be rewritten only while the queue has no response pending.
module strict_priority_multilevel_fifo (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // request channel
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [1:0]                       action_i,
  input  wire logic [spmf_pkg::LEVEL_W-1:0]     level_i,
  input  wire logic [spmf_pkg::ID_W-1:0]        record_id_i,
  input  wire logic [spmf_pkg::TAG_W-1:0]       record_tag_i,
  // response channel
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [spmf_pkg::STATUS_W-1:0]         status_o,
  output logic [spmf_pkg::ID_W-1:0]             out_id_o,
  output logic [spmf_pkg::TAG_W-1:0]            out_tag_o,
  output logic [spmf_pkg::LEVEL_W-1:0]          out_level_o,
  // configuration: top_level
  input  wire logic                             cfg_we_i,
  input  wire logic [spmf_pkg::LEVEL_W-1:0]     cfg_wdata_i
);

  logic                         accept;
  logic                         out_valid_q;
  spmf_pkg::res_t               res;
  spmf_pkg::res_t               res_q;
  spmf_pkg::mem_req_t           mem_req;
  logic [spmf_pkg::ENTRY_W-1:0] rd_data;
  logic                         removed;

  // Response register frees up in the same cycle it is drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  spmf_level_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .action_i     (action_i),
    .level_i      (level_i),
    .record_id_i  (record_id_i),
    .record_tag_i (record_tag_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .mem_req_o    (mem_req),
    .res_o        (res)
  );

  // Read data is loaded only on an accepted remove, so it holds while stalled
  spmf_store u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign removed = (res_q.status == spmf_pkg::ST_REMOVED);

  assign out_valid_o = out_valid_q;
  assign status_o    = res_q.status;
  assign out_level_o = res_q.level;
  // Record fields read as zero on every non-remove response
  assign out_id_o    = removed ? rd_data[spmf_pkg::ID_W-1:0] : '0;
  assign out_tag_o   = removed ? rd_data[spmf_pkg::ENTRY_W-1:spmf_pkg::ID_W] : '0;

  a_accept_gives_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted request produced no response");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !removed) |-> (out_id_o == '0 && out_tag_o == '0 && out_level_o == '0))
    else $error("non-remove response carries record fields");

  a_hold_rd_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i && removed) |=> $stable(rd_data))
    else $error("entry read data changed under a stalled response");

endmodule

`default_nettype wire

/* rtl/core/spmf_store.sv */
// Entry store: one record memory shared by all levels, registered read port.
`default_nettype none

module spmf_store (
  input  wire logic                         clk_i,
  input  wire spmf_pkg::mem_req_t           req_i,
  output logic [spmf_pkg::ENTRY_W-1:0]      rd_data_o
);

  logic [spmf_pkg::ENTRY_W-1:0] mem_q [spmf_pkg::MEM_DEPTH];
  logic [spmf_pkg::ENTRY_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

/* rtl/core/spmf_level_ctrl.sv */
// Per-level head and fill tracking, level select and request decode.
`default_nettype none

module spmf_level_ctrl (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             accept_i,
  input  wire logic [1:0]                       action_i,
  input  wire logic [spmf_pkg::LEVEL_W-1:0]     level_i,
  input  wire logic [spmf_pkg::ID_W-1:0]        record_id_i,
  input  wire logic [spmf_pkg::TAG_W-1:0]       record_tag_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [spmf_pkg::LEVEL_W-1:0]     cfg_wdata_i,
  output spmf_pkg::mem_req_t                    mem_req_o,
  output spmf_pkg::res_t                        res_o
);

  logic [spmf_pkg::PTR_W-1:0]   head_q [spmf_pkg::LEVELS];
  logic [spmf_pkg::CNT_W-1:0]   fill_q [spmf_pkg::LEVELS];
  logic [spmf_pkg::LEVEL_W-1:0] top_q;

  spmf_pkg::action_e          action;
  logic [spmf_pkg::LVL_W-1:0] start_lvl;
  logic [spmf_pkg::LVL_W-1:0] sel_lvl;
  logic                       found;
  logic                       lvl_ok;
  logic [spmf_pkg::LVL_W-1:0] ins_lvl;
  logic [spmf_pkg::LVL_W-1:0] idx;
  logic [spmf_pkg::PTR_W-1:0] head_sel;
  logic [spmf_pkg::CNT_W-1:0] fill_sel;
  logic [spmf_pkg::SUM_W-1:0] slot_sum;
  logic [spmf_pkg::SUM_W-1:0] slot_wide;
  logic [spmf_pkg::PTR_W-1:0] tail_slot;
  logic [spmf_pkg::PTR_W-1:0] head_nxt;
  logic                       full;
  logic                       do_inc;
  logic                       do_dec;
  logic                       do_clr;

  assign action = spmf_pkg::action_e'(action_i);

  // Remove searches from min(top, LEVELS-1) downward; highest non-empty wins
  always_comb begin
    start_lvl = (32'(top_q) >= 32'(spmf_pkg::LEVELS)) ?
                spmf_pkg::LVL_W'(spmf_pkg::LEVELS - 1) : spmf_pkg::LVL_W'(top_q);
    found   = 1'b0;
    sel_lvl = '0;
    for (int j = 0; j < int'(spmf_pkg::LEVELS); j++) begin
      if (fill_q[j] != '0 && spmf_pkg::LVL_W'(j) <= start_lvl) begin
        found   = 1'b1;
        sel_lvl = spmf_pkg::LVL_W'(j);
      end
    end
  end

  assign lvl_ok  = (32'(level_i) <= 32'(top_q)) && (32'(level_i) < 32'(spmf_pkg::LEVELS));
  assign ins_lvl = spmf_pkg::LVL_W'(level_i);
  assign idx     = (action == spmf_pkg::ACT_REMOVE) ? sel_lvl : ins_lvl;

  assign head_sel = head_q[idx];
  assign fill_sel = fill_q[idx];
  assign full     = (fill_sel == spmf_pkg::CNT_W'(spmf_pkg::DEPTH));

  // Tail slot = (head + fill) mod DEPTH; sum stays below twice DEPTH
  assign slot_sum  = spmf_pkg::SUM_W'(head_sel) + spmf_pkg::SUM_W'(fill_sel);
  assign slot_wide = (slot_sum >= spmf_pkg::SUM_W'(spmf_pkg::DEPTH)) ?
                     slot_sum - spmf_pkg::SUM_W'(spmf_pkg::DEPTH) : slot_sum;
  assign tail_slot = slot_wide[spmf_pkg::PTR_W-1:0];

  assign head_nxt = (32'(head_sel) == 32'(spmf_pkg::DEPTH - 1)) ?
                    '0 : head_sel + spmf_pkg::PTR_W'(1);

  always_comb begin
    mem_req_o       = '0;
    mem_req_o.wdata = {record_tag_i, record_id_i};
    res_o.status    = spmf_pkg::ST_DONE;
    res_o.level     = '0;
    do_inc          = 1'b0;
    do_dec          = 1'b0;
    do_clr          = 1'b0;
    unique case (action)
      spmf_pkg::ACT_INSERT: begin
        mem_req_o.addr = {idx, tail_slot};
        if (!lvl_ok) begin
          res_o.status = spmf_pkg::ST_BADLEVEL;
        end else if (full) begin
          res_o.status = spmf_pkg::ST_FULL;
        end else begin
          mem_req_o.wr_en = accept_i;
          do_inc          = 1'b1;
        end
      end
      spmf_pkg::ACT_REMOVE: begin
        mem_req_o.addr = {idx, head_sel};
        if (found) begin
          mem_req_o.rd_en = accept_i;
          res_o.status    = spmf_pkg::ST_REMOVED;
          res_o.level     = spmf_pkg::LEVEL_W'(sel_lvl);
          do_dec          = 1'b1;
        end else begin
          res_o.status = spmf_pkg::ST_EMPTY;
        end
      end
      spmf_pkg::ACT_CLEAR: begin
        do_clr = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < int'(spmf_pkg::LEVELS); j++) begin
        head_q[j] <= '0;
        fill_q[j] <= '0;
      end
    end else if (accept_i) begin
      if (do_clr) begin
        for (int j = 0; j < int'(spmf_pkg::LEVELS); j++) begin
          head_q[j] <= '0;
          fill_q[j] <= '0;
        end
      end else if (do_inc) begin
        fill_q[idx] <= fill_sel + spmf_pkg::CNT_W'(1);
      end else if (do_dec) begin
        fill_q[idx] <= fill_sel - spmf_pkg::CNT_W'(1);
        head_q[idx] <= head_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= spmf_pkg::TOP_RESET;
    end else if (cfg_we_i) begin
      top_q <= cfg_wdata_i;
    end
  end

  a_no_rd_wr_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req_o.wr_en && mem_req_o.rd_en))
    else $error("entry store read and written by one request");

  a_wr_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.wr_en |-> fill_sel != spmf_pkg::CNT_W'(spmf_pkg::DEPTH))
    else $error("write into a full level");

  a_rd_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.rd_en |-> (fill_sel != '0 && sel_lvl <= start_lvl))
    else $error("read from an empty or out-of-range level");

endmodule

`default_nettype wire
